FILE: hdl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int PAGES     = 4096;
    localparam int TOP_ORDER = 12;
    localparam int IDX_W     = 12;
    localparam int LINK_W    = 13;
    localparam int K_W       = 4;
    localparam int ORD_W     = 5;
    localparam int FRAME_W   = 40;
    localparam int TOTAL_W   = 13;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 64;

    localparam logic [LINK_W-1:0]  NIL_LINK = {LINK_W{1'b1}};

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_RANGE = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [1:0] STATUS_BAD_ORD = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_ZONE_BASE = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_ZONE_END  = 4'h8;

    typedef struct packed {
        logic             free;
        logic [ORD_W-1:0] order;
    } meta_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_A_FIND,
        S_A_SPLIT,
        S_F_CHK0,
        S_F_CHK1,
        S_F_RD0,
        S_F_MLOOP,
        S_F_BZ,
        S_F_BRD,
        S_R_INIT,
        S_R_LOOP,
        S_R_RD,
        S_PUT,
        S_PUSH_A,
        S_PUSH_B,
        S_U_A,
        S_U_B,
        S_U_C,
        S_FIN
    } state_t;

endpackage

FILE: hdl/bpa_if.sv
// ----------------------------------------------------------------------------
// bpa_req_if / bpa_rsp_if
// Valid/ready channels of the buddy page allocator.
// ----------------------------------------------------------------------------
interface bpa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [4:0]  block_order;
    logic [39:0] frame;
    logic [39:0] range_end_frame;

    modport source (output valid, func, block_order, frame, range_end_frame, input ready);
    modport sink   (input valid, func, block_order, frame, range_end_frame, output ready);
endinterface

interface bpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [39:0] granted_frame;
    logic [12:0] free_page_total;

    modport source (output valid, status, granted_frame, free_page_total, input ready);
    modport sink   (input valid, status, granted_frame, free_page_total, output ready);
endinterface

FILE: hdl/buddy_page_allocator_core.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_core
// Binary buddy allocator over a zone of 4096 page frames.
// ----------------------------------------------------------------------------
// After reset the page metadata memory is swept clear, one entry a cycle; no
// transaction is taken in that time, configuration writes are. Each
// transaction then runs through a sequencer around three simple dual-port
// memories (metadata, next link, prev link) with registered reads, so the
// time per transaction follows the number of memory steps: allocate grows
// with each split level, free with each merge level, and free-range with
// each chunk and each chunk placed. The sequencer returns to idle between
// transactions, and a result that is not taken holds the sequencer. One
// transaction is in work at a time; a result waits in the output register
// while the next request is accepted.
module buddy_page_allocator_core (
    input  logic                         clk,
    input  logic                         rst_n,
    bpa_req_if.sink                      req,
    bpa_rsp_if.source                    rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpa_pkg::PADDR_W-1:0]  paddr,
    input  logic [bpa_pkg::PDATA_W-1:0]  pwdata,
    output logic [bpa_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import bpa_pkg::*;

    meta_t              meta_mem [PAGES];
    logic [LINK_W-1:0]  next_mem [PAGES];
    logic [LINK_W-1:0]  prev_mem [PAGES];

    state_t             state_reg, state_next, ret_reg, ret_next;
    logic [IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [LINK_W-1:0]  head_reg [TOP_ORDER+1];
    logic [LINK_W-1:0]  head_next [TOP_ORDER+1];
    logic [FRAME_W-1:0] base_reg, base_next, zend_reg, zend_next;

    logic [1:0]         func_reg, func_next;
    logic [ORD_W-1:0]   ord_reg, ord_next;
    logic [FRAME_W-1:0] frame_reg, frame_next, rend_reg, rend_next;
    logic [FRAME_W-1:0] eff_reg, eff_next, b_reg, b_next;
    logic [K_W-1:0]     k_reg, k_next, sub_k_reg, sub_k_next;
    logic [IDX_W-1:0]   i_reg, i_next, sub_i_reg, sub_i_next;
    logic [1:0]         status_reg, status_next;
    logic [FRAME_W-1:0] granted_reg, granted_next;
    logic [1:0]         ostat_reg, ostat_next;
    logic [FRAME_W-1:0] ogrant_reg, ogrant_next;
    logic [TOTAL_W-1:0] ototal_reg, ototal_next;

    logic               meta_we, next_we, prev_we;
    logic [IDX_W-1:0]   meta_waddr, next_waddr, prev_waddr, meta_raddr, link_raddr;
    meta_t              meta_wdata, meta_rd;
    logic [LINK_W-1:0]  next_wdata, prev_wdata, next_rd, prev_rd;

    logic [FRAME_W-1:0] pfn_off, b_off, rlen;
    logic [IDX_W-1:0]   pfn_idx, b_idx;
    logic [FRAME_W:0]   base_lim, blk_end;
    logic               frame_in_zone, b_in_zone, ord_bad, found, split_more, brk;
    logic [K_W-1:0]     fk, k_dec, align, size, chunk_k;
    logic [LINK_W-1:0]  r_split;
    logic [LINK_W-1:0]  sub_head;

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_rd <= meta_mem[meta_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        next_rd <= next_mem[link_raddr];
        prev_rd <= prev_mem[link_raddr];
    end

    assign pready = 1'b1;

    always_comb
    begin
        case (paddr)
            ADDR_ZONE_BASE: prdata = {{(PDATA_W-FRAME_W){1'b0}}, base_reg};
            ADDR_ZONE_END:  prdata = {{(PDATA_W-FRAME_W){1'b0}}, zend_reg};
            default:        prdata = '0;
        endcase
    end

    always_comb
    begin
        base_next = base_reg;
        zend_next = zend_reg;
        if (psel && penable && pwrite)
        begin
            case (paddr)
                ADDR_ZONE_BASE: base_next = pwdata[FRAME_W-1:0];
                ADDR_ZONE_END:  zend_next = pwdata[FRAME_W-1:0];
                default:        base_next = base_reg;
            endcase
        end
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = ostat_reg;
    assign rsp.granted_frame   = ogrant_reg;
    assign rsp.free_page_total = ototal_reg;

    assign pfn_off       = frame_reg - base_reg;
    assign pfn_idx       = pfn_off[IDX_W-1:0];
    assign b_off         = b_reg - base_reg;
    assign b_idx         = b_off[IDX_W-1:0];
    assign base_lim      = {1'b0, base_reg} + (FRAME_W+1)'(PAGES);
    assign blk_end       = {1'b0, frame_reg} + ((FRAME_W+1)'(1) << ord_reg);
    assign frame_in_zone = (frame_reg >= base_reg) && (frame_reg < eff_reg);
    assign b_in_zone     = (b_reg >= base_reg) && (b_reg < eff_reg);
    assign ord_bad       = (ord_reg > ORD_W'(TOP_ORDER));
    assign k_dec         = k_reg - K_W'(1);
    assign r_split       = {1'b0, i_reg} + (LINK_W'(1) << k_dec);
    assign split_more    = ({1'b0, k_reg} > ord_reg);
    assign brk           = !meta_rd.free || (meta_rd.order != {1'b0, k_reg});
    assign rlen          = rend_reg - frame_reg;
    assign sub_head      = head_reg[sub_k_reg];

    always_comb
    begin
        found = 1'b0;
        fk    = '0;
        for (int j = TOP_ORDER; j >= 0; j--)
        begin
            if ((ORD_W'(j) >= ord_reg) && !head_reg[j][LINK_W-1])
            begin
                found = 1'b1;
                fk    = K_W'(j);
            end
        end
    end

    always_comb
    begin
        align = K_W'(TOP_ORDER);
        for (int j = IDX_W - 1; j >= 0; j--)
        begin
            if (frame_reg[j])
            begin
                align = K_W'(j);
            end
        end
        size = '0;
        if (|rlen[FRAME_W-1:IDX_W])
        begin
            size = K_W'(TOP_ORDER);
        end
        else
        begin
            for (int j = 1; j < IDX_W; j++)
            begin
                if (rlen[j])
                begin
                    size = K_W'(j);
                end
            end
        end
        chunk_k = (align < size) ? align : size;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:   if (clr_cnt_reg == {IDX_W{1'b1}}) state_next = S_IDLE;
            S_IDLE:    if (req.valid) state_next = S_PREP;
            S_PREP:
            begin
                case (func_reg)
                    FUNC_ALLOC: state_next = S_A_FIND;
                    FUNC_FREE:  state_next = S_F_CHK0;
                    FUNC_RANGE: state_next = S_R_INIT;
                    default:    state_next = S_FIN;
                endcase
            end
            S_A_FIND:  state_next = (ord_bad || !found) ? S_FIN : S_U_A;
            S_A_SPLIT:
            begin
                if (!split_more)
                    state_next = S_FIN;
                else if (!r_split[LINK_W-1])
                    state_next = S_PUT;
            end
            S_F_CHK0:  state_next = (ord_bad || !frame_in_zone) ? S_FIN : S_F_CHK1;
            S_F_CHK1:  state_next = (blk_end > {1'b0, eff_reg}) ? S_FIN : S_F_RD0;
            S_F_RD0:   state_next = meta_rd.free ? S_FIN : S_F_MLOOP;
            S_F_MLOOP: state_next = (k_reg == K_W'(TOP_ORDER)) ? S_PUT : S_F_BZ;
            S_F_BZ:    state_next = b_in_zone ? S_F_BRD : S_PUT;
            S_F_BRD:   state_next = brk ? S_PUT : S_U_A;
            S_R_INIT:  state_next = S_R_LOOP;
            S_R_LOOP:  state_next = (frame_reg < rend_reg) ? S_R_RD : S_FIN;
            S_R_RD:    state_next = meta_rd.free ? S_R_LOOP : S_PUT;
            S_PUT:     state_next = S_PUSH_A;
            S_PUSH_A:  state_next = S_PUSH_B;
            S_PUSH_B:  state_next = ret_reg;
            S_U_A:     state_next = S_U_B;
            S_U_B:     state_next = S_U_C;
            S_U_C:     state_next = ret_reg;
            S_FIN:     if (!out_valid_reg || rsp.ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ret_next       = ret_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        total_next     = total_reg;
        head_next      = head_reg;
        func_next      = func_reg;
        ord_next       = ord_reg;
        frame_next     = frame_reg;
        rend_next      = rend_reg;
        eff_next       = eff_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        sub_k_next     = sub_k_reg;
        sub_i_next     = sub_i_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        ostat_next     = ostat_reg;
        ogrant_next    = ogrant_reg;
        ototal_next    = ototal_reg;
        meta_we        = 1'b0;
        meta_waddr     = sub_i_reg;
        meta_wdata     = '0;
        meta_raddr     = pfn_idx;
        next_we        = 1'b0;
        next_waddr     = sub_i_reg;
        next_wdata     = NIL_LINK;
        prev_we        = 1'b0;
        prev_waddr     = sub_i_reg;
        prev_wdata     = NIL_LINK;
        link_raddr     = sub_i_reg;

        case (state_reg)
            S_CLEAR:
            begin
                meta_we      = 1'b1;
                meta_waddr   = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next    = req.func;
                    ord_next     = req.block_order;
                    frame_next   = req.frame;
                    rend_next    = req.range_end_frame;
                    status_next  = STATUS_OK;
                    granted_next = '0;
                end
            end
            S_PREP:
            begin
                eff_next = ({1'b0, zend_reg} < base_lim) ? zend_reg : base_lim[FRAME_W-1:0];
            end
            S_A_FIND:
            begin
                if (ord_bad)
                    status_next = STATUS_BAD_ORD;
                else if (!found)
                    status_next = STATUS_NO_FREE;
                else
                begin
                    i_next     = head_reg[fk][IDX_W-1:0];
                    k_next     = fk;
                    sub_i_next = head_reg[fk][IDX_W-1:0];
                    sub_k_next = fk;
                    ret_next   = S_A_SPLIT;
                    total_next = total_reg - (TOTAL_W'(1) << fk);
                end
            end
            S_A_SPLIT:
            begin
                if (split_more)
                begin
                    k_next     = k_dec;
                    sub_i_next = r_split[IDX_W-1:0];
                    sub_k_next = k_dec;
                    ret_next   = S_A_SPLIT;
                end
                else
                begin
                    meta_we      = 1'b1;
                    meta_waddr   = i_reg;
                    meta_wdata   = '{free: 1'b0, order: ord_reg};
                    granted_next = base_reg + {{(FRAME_W-IDX_W){1'b0}}, i_reg};
                end
            end
            S_F_CHK0:
            begin
                if (ord_bad)
                    status_next = STATUS_BAD_ORD;
                k_next = ord_reg[K_W-1:0];
            end
            S_F_MLOOP:
            begin
                sub_i_next = pfn_idx;
                sub_k_next = k_reg;
                ret_next   = S_FIN;
                b_next     = frame_reg ^ (FRAME_W'(1) << k_reg);
            end
            S_F_BZ:
            begin
                meta_raddr = b_idx;
                i_next     = b_idx;
            end
            S_F_BRD:
            begin
                if (!brk)
                begin
                    total_next = total_reg - (TOTAL_W'(1) << k_reg);
                    meta_we    = 1'b1;
                    meta_waddr = i_reg;
                    meta_wdata = '0;
                    frame_next = frame_reg & ~(FRAME_W'(1) << k_reg);
                    k_next     = k_reg + K_W'(1);
                    sub_i_next = i_reg;
                    sub_k_next = k_reg;
                    ret_next   = S_F_MLOOP;
                end
            end
            S_R_INIT:
            begin
                frame_next = (frame_reg < base_reg) ? base_reg : frame_reg;
                rend_next  = (rend_reg > eff_reg) ? eff_reg : rend_reg;
            end
            S_R_LOOP:
            begin
                k_next = chunk_k;
                i_next = pfn_idx;
            end
            S_R_RD:
            begin
                frame_next = frame_reg + (FRAME_W'(1) << k_reg);
                sub_i_next = i_reg;
                sub_k_next = k_reg;
                ret_next   = S_R_LOOP;
            end
            S_PUT:
            begin
                meta_we    = 1'b1;
                meta_wdata = '{free: 1'b1, order: {1'b0, sub_k_reg}};
                total_next = total_reg + (TOTAL_W'(1) << sub_k_reg);
            end
            S_PUSH_A:
            begin
                next_we    = 1'b1;
                next_wdata = sub_head;
                prev_we    = 1'b1;
            end
            S_PUSH_B:
            begin
                if (!sub_head[LINK_W-1])
                begin
                    prev_we    = 1'b1;
                    prev_waddr = sub_head[IDX_W-1:0];
                    prev_wdata = {1'b0, sub_i_reg};
                end
                head_next[sub_k_reg] = {1'b0, sub_i_reg};
            end
            S_U_B:
            begin
                if (!prev_rd[LINK_W-1])
                begin
                    next_we    = 1'b1;
                    next_waddr = prev_rd[IDX_W-1:0];
                    next_wdata = next_rd;
                end
                else
                begin
                    head_next[sub_k_reg] = next_rd;
                end
                if (!next_rd[LINK_W-1])
                begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rd[IDX_W-1:0];
                    prev_wdata = prev_rd;
                end
            end
            S_U_C:
            begin
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    ostat_next     = status_reg;
                    ogrant_next    = granted_reg;
                    ototal_next    = total_reg;
                end
            end
            default:
            begin
                ret_next = ret_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_reg       <= S_FIN;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            base_reg      <= '0;
            zend_reg      <= '0;
            for (int j = 0; j <= TOP_ORDER; j++)
            begin
                head_reg[j] <= NIL_LINK;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
            base_reg      <= base_next;
            zend_reg      <= zend_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        ord_reg     <= ord_next;
        frame_reg   <= frame_next;
        rend_reg    <= rend_next;
        eff_reg     <= eff_next;
        b_reg       <= b_next;
        k_reg       <= k_next;
        i_reg       <= i_next;
        sub_k_reg   <= sub_k_next;
        sub_i_reg   <= sub_i_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        ostat_reg   <= ostat_next;
        ogrant_reg  <= ogrant_next;
        ototal_reg  <= ototal_next;
    end

endmodule
